/* rtl/lj_pkg.sv */
// Shared widths, constants and the per-pair sideband for the Lennard-Jones pair force pipeline.
// No dependencies.
package lj_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned WIDE_W    = 2 * WORD_W;
  localparam int unsigned DIV_STEPS = WIDE_W;
  localparam int unsigned MUL_LAT   = 2;
  localparam int unsigned AXES      = 3;
  localparam int unsigned ADDR_W    = 3;

  localparam logic [ADDR_W-3:0] REG_EPSILON = '0;
  localparam logic [WORD_W-1:0] EPSILON_RESET = 32'h0001_0000;

  localparam logic [WIDE_W-1:0] WIDE_MAX    = '1;
  localparam logic [WIDE_W-1:0] MAX_OVER_12 = 64'h1555_5555_5555_5555;
  localparam logic [WORD_W-1:0] POS_MAX     = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] NEG_MAX     = 32'h8000_0000;

  typedef struct packed {
    logic            valid;
    logic            cut;
    logic            zero;
    logic [AXES-1:0] rneg;
    logic [AXES-1:0] rzero;
  } lj_side_t;

endpackage

/* rtl/lj_delay.sv */
// Enabled shift line that carries values alongside the arithmetic pipeline.
// Depends on lj_pkg.
module lj_delay
  import lj_pkg::*;
#(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DEPTH; k++) taps[k] <= '0;
    end else if (en) begin
      taps[0] <= din;
      for (int k = 1; k < DEPTH; k++) taps[k] <= taps[k-1];
    end
  end

  assign dout = taps[DEPTH-1];

endmodule

/* rtl/lj_div.sv */
// Pipelined restoring divider: floor((num << 32) / den), one quotient bit per stage.
// Depends on lj_pkg.
module lj_div
  import lj_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [WORD_W-1:0] num,
  input  logic [WORD_W-1:0] den,
  output logic [WIDE_W-1:0] quo
);

  logic [WORD_W-1:0] rem_s [DIV_STEPS];
  logic [WORD_W-1:0] num_s [DIV_STEPS];
  logic [WORD_W-1:0] den_s [DIV_STEPS];
  logic [WIDE_W-1:0] quo_s [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [WORD_W-1:0] rem_in, num_in, den_in;
    logic [WIDE_W-1:0] quo_in;
    logic [WORD_W:0]   trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_rest
      assign rem_in = rem_s[k-1];
      assign num_in = num_s[k-1];
      assign den_in = den_s[k-1];
      assign quo_in = quo_s[k-1];
    end

    // numerator bits first, then the zero fraction bits
    if (k < WORD_W) begin : g_hi
      assign trial = {rem_in, num_in[WORD_W-1-k]};
    end else begin : g_lo
      assign trial = {rem_in, 1'b0};
    end

    assign ge = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k] <= ge ? WORD_W'(trial - {1'b0, den_in}) : trial[WORD_W-1:0];
        num_s[k] <= num_in;
        den_s[k] <= den_in;
        quo_s[k] <= {quo_in[WIDE_W-2:0], ge};
      end
    end
  end

  assign quo = quo_s[DIV_STEPS-1];

endmodule

/* rtl/lj_mul.sv */
// Two-stage 64x64 multiply keeping bits 95:32, saturating to all ones on overflow.
// Depends on lj_pkg.
module lj_mul
  import lj_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [WIDE_W-1:0] a,
  input  logic [WIDE_W-1:0] b,
  output logic [WIDE_W-1:0] prod,
  output logic              clip
);

  logic [WIDE_W-1:0] p00, p01, p10, p11;
  logic [WORD_W+1:0] mid;
  logic [WIDE_W+1:0] hi;

  always_ff @(posedge clk) begin
    if (en) begin
      p00 <= a[WORD_W-1:0] * b[WORD_W-1:0];
      p01 <= a[WORD_W-1:0] * b[WIDE_W-1:WORD_W];
      p10 <= a[WIDE_W-1:WORD_W] * b[WORD_W-1:0];
      p11 <= a[WIDE_W-1:WORD_W] * b[WIDE_W-1:WORD_W];
    end
  end

  always_comb begin
    mid = {2'b0, p00[WIDE_W-1:WORD_W]} + {2'b0, p01[WORD_W-1:0]}
        + {2'b0, p10[WORD_W-1:0]};
    hi  = {2'b0, p11} + {34'b0, p01[WIDE_W-1:WORD_W]} + {34'b0, p10[WIDE_W-1:WORD_W]}
        + {64'b0, mid[WORD_W+1:WORD_W]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (hi[WIDE_W+1:WORD_W] != '0) begin
        prod <= WIDE_MAX;
        clip <= 1'b1;
      end else begin
        prod <= {hi[WORD_W-1:0], mid[WORD_W-1:0]};
        clip <= 1'b0;
      end
    end
  end

endmodule

/* rtl/lennard_jones_pair_force.sv */
// Lennard-Jones 12-6 pair force and energy in Q16.16 fixed point, with an APB register.
// Depends on lj_pkg, lj_div, lj_mul and lj_delay.
//
// One particle pair enters per clock while in_stall is low, and its force vector, energy
// and saturation flag leave at the end of the pipeline, whose depth is set by the four
// 64-step restoring dividers (R2/r2 and r_i/r2) followed by a chain of two-stage 64-bit
// multipliers. The pipeline advances as a whole: while a result sits stalled at the
// output, in_stall is high. Pairs beyond r2 > 6.25*R2 return zeros. Epsilon lives at
// byte address 0 and must be written only while no pair is in flight.
module lennard_jones_pair_force
  import lj_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [WORD_W-1:0]        pwdata,
  output logic [WORD_W-1:0]        prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [WORD_W-1:0] r_x,
  input  logic signed [WORD_W-1:0] r_y,
  input  logic signed [WORD_W-1:0] r_z,
  input  logic [WORD_W-1:0]        dist_squared,
  input  logic [WORD_W-1:0]        radii_squared,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [WORD_W-1:0] force_x,
  output logic signed [WORD_W-1:0] force_y,
  output logic signed [WORD_W-1:0] force_z,
  output logic signed [WORD_W-1:0] energy,
  output logic                     saturated
);

  function automatic logic [WORD_W:0] pack32(logic [WIDE_W-1:0] mag, logic neg);
    logic [WORD_W:0] res;
    if (neg) begin
      if (mag > {32'b0, NEG_MAX}) res = {1'b1, NEG_MAX};
      else res = {1'b0, WORD_W'(~mag[WORD_W-1:0] + 1'b1)};
    end else begin
      if (mag > {32'b0, POS_MAX}) res = {1'b1, POS_MAX};
      else res = {1'b0, mag[WORD_W-1:0]};
    end
    return res;
  endfunction

  logic [WORD_W-1:0] epsilon;
  logic              en;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1:2] == REG_EPSILON) ? epsilon : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon <= EPSILON_RESET;
    end else if (psel && penable && pwrite && paddr[ADDR_W-1:2] == REG_EPSILON) begin
      epsilon <= pwdata;
    end
  end

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // input stage
  lj_side_t          side0;
  logic [WORD_W-1:0] rsq0, rad0;
  logic [WORD_W-1:0] rmag0 [AXES];
  logic [WORD_W-1:0] rin   [AXES];
  logic [WORD_W+1:0] four_rsq;
  logic [WORD_W+4:0] rad25;

  assign rin[0] = r_x;
  assign rin[1] = r_y;
  assign rin[2] = r_z;
  assign four_rsq = {dist_squared, 2'b0};
  assign rad25 = {radii_squared, 5'b0} - {2'b0, radii_squared, 3'b0}
               + {5'b0, radii_squared};

  always_ff @(posedge clk) begin
    if (rst) begin
      side0.valid <= 1'b0;
    end else if (en) begin
      side0.valid <= in_valid;
    end
    if (en) begin
      side0.cut  <= {3'b0, four_rsq} > rad25;
      side0.zero <= dist_squared == '0;
      rsq0 <= dist_squared;
      rad0 <= radii_squared;
      for (int i = 0; i < AXES; i++) begin
        side0.rneg[i]  <= rin[i][WORD_W-1];
        side0.rzero[i] <= rin[i] == '0;
        rmag0[i] <= rin[i][WORD_W-1] ? WORD_W'(~rin[i] + 1'b1) : rin[i];
      end
    end
  end

  // ratios R2/r2 and |r_i|/r2
  logic [WIDE_W-1:0] q;
  logic [WIDE_W-1:0] w [AXES];

  lj_div u_div_q (.clk, .en, .num(rad0), .den(rsq0), .quo(q));

  for (genvar i = 0; i < AXES; i++) begin : g_wdiv
    lj_div u_div_w (.clk, .en, .num(rmag0[i]), .den(rsq0), .quo(w[i]));
  end

  // powers of the ratio
  logic [WIDE_W-1:0] q2, q_d, u, u_d, u2;
  logic              clip_q2, clip_q2_d, clip_u, huge, clip_qu, clip_qu_d;

  lj_mul u_mul_q2 (.clk, .en, .a(q), .b(q), .prod(q2), .clip(clip_q2));
  lj_delay #(.WIDTH(WIDE_W), .DEPTH(MUL_LAT)) u_dly_q (
    .clk, .rst, .en, .din(q), .dout(q_d));
  lj_mul u_mul_u (.clk, .en, .a(q2), .b(q_d), .prod(u), .clip(clip_u));
  lj_delay #(.WIDTH(1), .DEPTH(MUL_LAT)) u_dly_cq2 (
    .clk, .rst, .en, .din(clip_q2), .dout(clip_q2_d));
  assign clip_qu = clip_q2_d | clip_u;
  lj_mul u_mul_u2 (.clk, .en, .a(u), .b(u), .prod(u2), .clip(huge));
  lj_delay #(.WIDTH(WIDE_W), .DEPTH(MUL_LAT)) u_dly_u (
    .clk, .rst, .en, .din(u), .dout(u_d));
  lj_delay #(.WIDTH(1), .DEPTH(MUL_LAT)) u_dly_cqu (
    .clk, .rst, .en, .din(clip_qu), .dout(clip_qu_d));

  // differences u^2 - 2u and u^2 - u
  logic [WIDE_W-1:0] me, mf, twou;
  logic              eneg, fpos, clip_b;

  assign twou = {u_d[WIDE_W-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      clip_b <= clip_qu_d | huge;
      if (huge) begin
        me   <= WIDE_MAX;
        mf   <= WIDE_MAX;
        eneg <= 1'b0;
        fpos <= 1'b1;
      end else begin
        eneg <= u2 < twou;
        me   <= (u2 < twou) ? twou - u2 : u2 - twou;
        fpos <= u2 >= u_d;
        mf   <= (u2 >= u_d) ? u2 - u_d : u_d - u2;
      end
    end
  end

  // scale by epsilon and the axis ratios
  logic [WIDE_W-1:0] eps_w, emag, emag_d;
  logic              clip_e, clip_e_d, eneg_d, fpos_d, clip_b_d;
  logic [WIDE_W-1:0] w_d [AXES];
  logic [WIDE_W-1:0] t   [AXES];
  logic [WIDE_W-1:0] p   [AXES];
  logic              clip_t [AXES];
  logic              clip_t_d [AXES];
  logic              clip_p [AXES];

  assign eps_w = {32'b0, epsilon};

  lj_mul u_mul_e (.clk, .en, .a(me), .b(eps_w), .prod(emag), .clip(clip_e));
  lj_delay #(.WIDTH(WIDE_W + 1), .DEPTH(MUL_LAT)) u_dly_e (
    .clk, .rst, .en, .din({emag, clip_e}), .dout({emag_d, clip_e_d}));
  lj_delay #(.WIDTH(3), .DEPTH(2 * MUL_LAT)) u_dly_flags (
    .clk, .rst, .en, .din({eneg, fpos, clip_b}), .dout({eneg_d, fpos_d, clip_b_d}));

  for (genvar i = 0; i < AXES; i++) begin : g_axis
    lj_delay #(.WIDTH(WIDE_W), .DEPTH(3 * MUL_LAT + 1)) u_dly_w (
      .clk, .rst, .en, .din(w[i]), .dout(w_d[i]));
    lj_mul u_mul_t (.clk, .en, .a(mf), .b(w_d[i]), .prod(t[i]), .clip(clip_t[i]));
    lj_mul u_mul_p (.clk, .en, .a(t[i]), .b(eps_w), .prod(p[i]), .clip(clip_p[i]));
    lj_delay #(.WIDTH(1), .DEPTH(MUL_LAT)) u_dly_ct (
      .clk, .rst, .en, .din(clip_t[i]), .dout(clip_t_d[i]));
  end

  // sideband follows the data to the output stage
  lj_side_t side_f;

  lj_delay #(.WIDTH($bits(lj_side_t)), .DEPTH(DIV_STEPS + 5 * MUL_LAT + 1)) u_dly_side (
    .clk, .rst, .en, .din(side0), .dout(side_f));

  // output stage: times 12, sign and clip
  logic [WORD_W:0]   e_pk;
  logic [WORD_W:0]   f_pk [AXES];
  logic [WIDE_W-1:0] p12  [AXES];
  logic [WORD_W-1:0] f_out [AXES];
  logic              over [AXES];
  logic              sat_all;

  always_comb begin
    e_pk = pack32(emag_d, eneg_d && emag_d != '0);
    sat_all = clip_b_d | clip_e_d | e_pk[WORD_W];
    for (int i = 0; i < AXES; i++) begin
      over[i] = p[i] > MAX_OVER_12;
      p12[i]  = over[i] ? WIDE_MAX : {p[i][WIDE_W-4:0], 3'b0} + {p[i][WIDE_W-3:0], 2'b0};
      f_pk[i] = pack32(p12[i], (fpos_d == !side_f.rneg[i]) && p[i] != '0);
      sat_all = sat_all | clip_t_d[i] | clip_p[i] | over[i] | f_pk[i][WORD_W];
    end
    for (int i = 0; i < AXES; i++) begin
      if (side_f.cut) f_out[i] = '0;
      else if (side_f.zero) begin
        if (side_f.rzero[i]) f_out[i] = '0;
        else f_out[i] = side_f.rneg[i] ? POS_MAX : NEG_MAX;
      end else f_out[i] = f_pk[i][WORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= side_f.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      force_x <= f_out[0];
      force_y <= f_out[1];
      force_z <= f_out[2];
      if (side_f.cut) begin
        energy    <= '0;
        saturated <= 1'b0;
      end else if (side_f.zero) begin
        energy    <= POS_MAX;
        saturated <= 1'b1;
      end else begin
        energy    <= e_pk[WORD_W-1:0];
        saturated <= sat_all;
      end
    end
  end

endmodule
